/* rtl/rfns_pkg.sv */
`default_nettype none
package rfns_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W    = HEIGHT_W;
	localparam int CFG_IDX_W = 1;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		pix_t             pix;
		logic             frame_end;
	} res_t;

	// write side of the line store
	typedef struct packed {
		logic             orig_en;
		logic             smooth_en;
		logic [COL_W-1:0] col;
		pix_t             orig;
		pix_t             smooth;
	} ls_wr_t;

	function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		logic [9:0] sum;
		sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
		return sum[9:2];
	endfunction

	function automatic pix_t mean4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
		pix_t res;
		res.red   = avg4(a.red, b.red, c.red, d.red);
		res.green = avg4(a.green, b.green, c.green, d.green);
		res.blue  = avg4(a.blue, b.blue, c.blue, d.blue);
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/rfns_stream_if.sv */
`default_nettype none
interface rfns_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rfns_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        frame_end;

	modport source (output valid, output out_row, output out_col, output red_out,
		output green_out, output blue_out, output frame_end, input ready);
	modport sink (input valid, input out_row, input out_col, input red_out,
		input green_out, input blue_out, input frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/rfns_line_store.sv */
`default_nettype none
module rfns_line_store (
	input  wire                           clk,
	input  wire                           rd_en,
	input  wire  [rfns_pkg::COL_W-1:0]    rd_col,
	input  rfns_pkg::ls_wr_t              wr,
	output rfns_pkg::pix_t                orig_here,
	output rfns_pkg::pix_t                orig_right,
	output rfns_pkg::pix_t                smooth_above
);

	rfns_pkg::pix_t orig_mem   [rfns_pkg::MAX_WIDTH];
	rfns_pkg::pix_t smooth_mem [rfns_pkg::MAX_WIDTH];

	logic [rfns_pkg::COL_W-1:0] rd_col_next;
	rfns_pkg::pix_t orig_here_q, orig_right_q, smooth_q;
	rfns_pkg::pix_t fwd_orig_q, fwd_smooth_q;
	logic hit_here_q, hit_right_q, hit_smooth_q;

	// right neighbor wraps at the last column, where it is never used
	assign rd_col_next = rfns_pkg::COL_W'(rd_col + 1'b1);

	always_ff @(posedge clk) begin
		if (wr.orig_en) begin
			orig_mem[wr.col] <= wr.orig;
		end
		if (wr.smooth_en) begin
			smooth_mem[wr.col] <= wr.smooth;
		end
		if (rd_en) begin
			orig_here_q  <= orig_mem[rd_col];
			orig_right_q <= orig_mem[rd_col_next];
			smooth_q     <= smooth_mem[rd_col];
			// same-edge write bypass
			hit_here_q   <= wr.orig_en && (wr.col == rd_col);
			hit_right_q  <= wr.orig_en && (wr.col == rd_col_next);
			hit_smooth_q <= wr.smooth_en && (wr.col == rd_col);
			fwd_orig_q   <= wr.orig;
			fwd_smooth_q <= wr.smooth;
		end
	end

	assign orig_here    = hit_here_q ? fwd_orig_q : orig_here_q;
	assign orig_right   = hit_right_q ? fwd_orig_q : orig_right_q;
	assign smooth_above = hit_smooth_q ? fwd_smooth_q : smooth_q;

endmodule
`default_nettype wire

/* rtl/rfns_result_fifo.sv */
`default_nettype none
module rfns_result_fifo (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [1:0]                       push_cnt,
	input  rfns_pkg::res_t                   entry_a,
	input  rfns_pkg::res_t                   entry_b,
	input  wire                              pop,
	output logic                             valid,
	output rfns_pkg::res_t                   head,
	output logic [rfns_pkg::FIFO_CNT_W-1:0]  count
);

	rfns_pkg::res_t mem [rfns_pkg::FIFO_DEPTH];

	logic [rfns_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_next;
	logic [rfns_pkg::FIFO_CNT_W-1:0] count_q;

	assign wr_ptr_next = rfns_pkg::FIFO_PTR_W'(wr_ptr_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= rfns_pkg::FIFO_PTR_W'(wr_ptr_q + push_cnt);
			if (pop) begin
				rd_ptr_q <= rfns_pkg::FIFO_PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= rfns_pkg::FIFO_CNT_W'(count_q + rfns_pkg::FIFO_CNT_W'(push_cnt)
				- rfns_pkg::FIFO_CNT_W'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_ptr_q] <= entry_a;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_ptr_next] <= entry_b;
		end
	end

	assign valid = (count_q != '0);
	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule
`default_nettype wire

/* rtl/rgb_four_neighbor_smoothing_unit.sv */
// rgb four-neighbor smoothing unit
//
// pixel: raster-order rgb pixel requests (8 bits per channel), valid/ready,
// taken at a rising edge with valid and ready high
// result: (out_row, out_col, rgb, frame_end) requests, valid/ready
// cfg: write port; out-of-range values are clamped; index 0 = image_width,
// index 1 = image_height; write only while no pixel is in flight (not checked)
//
// interior pixels become the per-channel truncated mean of their four
// neighbors (upper and left already smoothed, lower and right original);
// border rows and columns pass through. row r-1 is emitted while row r
// arrives; each last-row pixel also emits itself after the pixel above it
//
// pipeline: line store read at the accepting edge; mean and queue write
// from the stage 1 registers; a result is offered once it is in the queue
// throughput: one pixel per cycle while results are taken; in the last
// row two results per pixel against one result per cycle halve it
// reset: row 0 column 0, registers 1024 x 1024, result queue empty
// stall: a four-entry queue holds results; pixel ready drops when it cannot
// take two more beyond the results already on their way in
`default_nettype none
module rgb_four_neighbor_smoothing_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [rfns_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [rfns_pkg::CFG_W-1:0]         cfg_data,
	rfns_pix_if.sink                           pixel,
	rfns_res_if.source                         result
);

	// configuration
	logic [rfns_pkg::WIDTH_W-1:0]  width_q, width_eff;
	logic [rfns_pkg::HEIGHT_W-1:0] height_q, height_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rfns_pkg::WIDTH_RESET;
			height_q <= rfns_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rfns_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[rfns_pkg::WIDTH_W-1:0];
				end
				rfns_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[rfns_pkg::HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp to 1..max
	always_comb begin
		if (width_q == '0) begin
			width_eff = rfns_pkg::WIDTH_W'(1);
		end else if (width_q > rfns_pkg::WIDTH_W'(rfns_pkg::MAX_WIDTH)) begin
			width_eff = rfns_pkg::WIDTH_W'(rfns_pkg::MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = rfns_pkg::HEIGHT_W'(1);
		end else if (height_q > rfns_pkg::HEIGHT_W'(rfns_pkg::MAX_HEIGHT)) begin
			height_eff = rfns_pkg::HEIGHT_W'(rfns_pkg::MAX_HEIGHT);
		end else begin
			height_eff = height_q;
		end
	end

	// input position and per-pixel flags
	logic [rfns_pkg::ROW_W-1:0] row_q;
	logic [rfns_pkg::COL_W-1:0] col_q;
	logic accept, last_col, last_row, border, above;
	rfns_pkg::pix_t cur;

	assign accept   = pixel.valid && pixel.ready;
	assign cur      = '{red: pixel.red_in, green: pixel.green_in, blue: pixel.blue_in};
	assign last_col = ({1'b0, col_q} + 1'b1) >= width_eff;
	assign last_row = ({1'b0, row_q} + 1'b1) >= height_eff;
	assign above    = (row_q != '0);
	// first row, first and last columns, and the last storable column
	assign border   = (row_q == rfns_pkg::ROW_W'(1)) || (col_q == '0) || last_col ||
		(col_q == rfns_pkg::COL_W'(rfns_pkg::MAX_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : rfns_pkg::ROW_W'(row_q + 1'b1);
			end else begin
				col_q <= rfns_pkg::COL_W'(col_q + 1'b1);
			end
		end
	end

	// stage 1: line store data arrives, mean and write-back
	logic                       valid_s1, above_s1, border_s1, last_row_s1, last_col_s1;
	logic [rfns_pkg::ROW_W-1:0] row_s1;
	logic [rfns_pkg::COL_W-1:0] col_s1;
	rfns_pkg::pix_t             cur_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1    <= above;
			border_s1   <= border;
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
			row_s1      <= row_q;
			col_s1      <= col_q;
			cur_s1      <= cur;
		end
	end

	rfns_pkg::ls_wr_t ls_wr;
	rfns_pkg::pix_t   orig_here, orig_right, smooth_above, val, left_q;

	rfns_line_store u_line_store (
		.clk          (clk),
		.rd_en        (accept),
		.rd_col       (col_q),
		.wr           (ls_wr),
		.orig_here    (orig_here),
		.orig_right   (orig_right),
		.smooth_above (smooth_above)
	);

	assign val = border_s1 ? orig_here :
		rfns_pkg::mean4(smooth_above, cur_s1, left_q, orig_right);

	assign ls_wr = '{orig_en: valid_s1, smooth_en: valid_s1 && above_s1, col: col_s1,
		orig: cur_s1, smooth: val};

	// last value emitted for the row above feeds the next pixel as its left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (valid_s1 && above_s1) begin
			left_q <= val;
		end
	end

	// result queue
	logic emit_above, emit_own, fifo_valid, pop;
	logic [1:0] push_cnt;
	logic [rfns_pkg::FIFO_CNT_W-1:0] fifo_count, pending;
	rfns_pkg::res_t res_above, res_own, entry_a, fifo_head;

	assign emit_above = valid_s1 && above_s1;
	assign emit_own   = valid_s1 && last_row_s1;
	assign push_cnt   = {1'b0, emit_above} + {1'b0, emit_own};

	assign res_above = '{row: rfns_pkg::ROW_W'(row_s1 - 1'b1), col: col_s1, pix: val,
		frame_end: 1'b0};
	assign res_own   = '{row: row_s1, col: col_s1, pix: cur_s1, frame_end: last_col_s1};
	assign entry_a   = emit_above ? res_above : res_own;

	assign pop = result.valid && result.ready;

	rfns_result_fifo u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.entry_a  (entry_a),
		.entry_b  (res_own),
		.pop      (pop),
		.valid    (fifo_valid),
		.head     (fifo_head),
		.count    (fifo_count)
	);

	// room for the pixel in stage 1 plus two results of a new one
	assign pending     = rfns_pkg::FIFO_CNT_W'(push_cnt);
	assign pixel.ready = rfns_pkg::FIFO_CNT_W'(fifo_count + pending)
		<= rfns_pkg::FIFO_CNT_W'(rfns_pkg::FIFO_DEPTH - 2);

	assign result.valid     = fifo_valid;
	assign result.out_row   = fifo_head.row;
	assign result.out_col   = fifo_head.col;
	assign result.red_out   = fifo_head.pix.red;
	assign result.green_out = fifo_head.pix.green;
	assign result.blue_out  = fifo_head.pix.blue;
	assign result.frame_end = fifo_head.frame_end;

endmodule
`default_nettype wire

/* rtl/rfns_checker.sv */
`default_nettype none
module rfns_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [11:0] out_row,
	input wire [9:0]  out_col,
	input wire [7:0]  red_out,
	input wire [7:0]  green_out,
	input wire [7:0]  blue_out,
	input wire        frame_end
);

	// each pixel is worth at most two results
	logic [13:0] credit_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (credit_q != '1) begin
			credit_q <= 14'(credit_q + (in_acc ? 14'd2 : 14'd0) - (out_acc ? 14'd1 : 14'd0));
		end
	end

	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result offered during reset");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> credit_q != '0)
		else $error("result without a pixel behind it");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) &&
		$stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_end))
		else $error("result changed while stalled");

endmodule

bind rgb_four_neighbor_smoothing_unit rfns_checker u_rfns_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_row   (result.out_row),
	.out_col   (result.out_col),
	.red_out   (result.red_out),
	.green_out (result.green_out),
	.blue_out  (result.blue_out),
	.frame_end (result.frame_end)
);
`default_nettype wire
